// File: rtl/core/pgf_pkg.sv
// Package for the path gap filler and smoother: sizes, configuration and
// queue entry types, register indexes and small shared helper functions.
// No dependencies.
package pgf_pkg;

   localparam int MAX_HALF   = 4;
   localparam int MAX_INTERP = 15;
   localparam int COORD_BITS = 20;

   localparam int HIST      = 2 * MAX_HALF + 1;
   localparam int HALF_W    = $clog2(MAX_HALF + 1);
   localparam int HIST_W    = $clog2(HIST + 1);
   localparam int HIDX_W    = $clog2(HIST);
   localparam int N_W       = $clog2(MAX_INTERP + 1);
   localparam int CNT_W     = $clog2(MAX_INTERP + 2);
   localparam int NUM_W     = COORD_BITS + CNT_W;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);
   localparam int GAP_W     = 20;
   localparam int HWIN_W    = 3;
   localparam int WGT_W     = 16;
   localparam int NUM_TAPS  = 5;
   localparam int SQ_W      = 2 * COORD_BITS;
   localparam int D2_W      = SQ_W + 1;
   localparam int S_W       = GAP_W + CNT_W;
   localparam int ACC_W     = COORD_BITS + WGT_W + HALF_W + 1;
   localparam int ROUND_ADD = 32768;
   localparam int FRAC_W    = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 20;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_GAP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_WINDOW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_W_CENTER    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_W_OFF1      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_W_OFF2      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_W_OFF3      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_W_OFF4      = 3'd6;

   localparam logic [GAP_W-1:0]  RST_MAX_GAP     = 20'd256;
   localparam logic [HWIN_W-1:0] RST_HALF_WINDOW = 3'd2;
   localparam logic [WGT_W-1:0]  RST_W_CENTER    = 16'd26214;
   localparam logic [WGT_W-1:0]  RST_W_OFF1      = 16'd16384;
   localparam logic [WGT_W-1:0]  RST_W_OFF2      = 16'd8192;
   localparam logic [WGT_W-1:0]  RST_W_OFF3      = 16'd0;
   localparam logic [WGT_W-1:0]  RST_W_OFF4      = 16'd0;

   localparam logic [COORD_BITS-1:0] COORD_MASK = '1;

   typedef struct packed {
      logic [GAP_W-1:0]                 max_gap;
      logic [HWIN_W-1:0]                half_window;
      logic [NUM_TAPS-1:0][WGT_W-1:0]   weight;
   } cfg_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pt_x;
      logic [COORD_BITS-1:0] pt_y;
      logic [COORD_BITS-1:0] prev_x;
      logic [COORD_BITS-1:0] prev_y;
      logic [N_W-1:0]        n_pts;
      logic                  sat;
      logic                  fin;
   } job_type;

   function automatic logic [HALF_W-1:0] eff_half(input logic [HWIN_W-1:0] hw);
      if (int'(hw) > MAX_HALF) begin
         return HALF_W'(MAX_HALF);
      end
      return HALF_W'(hw);
   endfunction

   function automatic logic [WGT_W-1:0] tap_weight(input cfg_type cfg,
                                                  input logic [HALF_W-1:0] d);
      logic [WGT_W-1:0] w;
      w = '0;
      for (int t = 0; t < NUM_TAPS; t++) begin
         if (int'(d) == t) begin
            w = cfg.weight[t];
         end
      end
      return w;
   endfunction

endpackage

// File: rtl/core/pgf_if.sv
// Channel interfaces of the path gap filler: waypoint request channel and
// result response channel. Depends on pgf_pkg.
interface pgf_req_if import pgf_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;
   logic                  final_point;

   modport source(output valid, point_x, point_y, final_point, input ready);
   modport sink(input valid, point_x, point_y, final_point, output ready);
endinterface

interface pgf_rsp_if import pgf_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] out_x;
   logic [COORD_BITS-1:0] out_y;
   logic                  was_smoothed;
   logic                  gap_saturated;
   logic                  end_of_run;

   modport source(output valid, out_x, out_y, was_smoothed, gap_saturated, end_of_run,
                  input ready);
   modport sink(input valid, out_x, out_y, was_smoothed, gap_saturated, end_of_run,
                output ready);
endinterface

// File: rtl/core/pgf_front.sv
// Front end: accepts waypoints, measures the gap to the previous one and
// finds how many points to insert. Depends on pgf_pkg and pgf_if.
module pgf_front import pgf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   pgf_req_if.sink          req,
   input  logic [GAP_W-1:0] max_gap,
   output job_type          job,
   output logic             job_valid,
   input  logic             job_ready
);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_SQ   = 3'd1;
   localparam logic [2:0] F_SUM  = 3'd2;
   localparam logic [2:0] F_SRCH = 3'd3;
   localparam logic [2:0] F_PUSH = 3'd4;

   logic [2:0]            state_ff, state_in;
   job_type               cur_ff, cur_in;
   logic [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                  have_prev_ff, have_prev_in;
   logic [SQ_W-1:0]       dxx_ff, dxx_in, dyy_ff, dyy_in;
   logic [D2_W-1:0]       d2_ff, d2_in;
   logic [S_W-1:0]        s_ff, s_in;
   logic [CNT_W-1:0]      m_ff, m_in;
   logic [COORD_BITS-1:0] dx, dy;
   logic [2*S_W-1:0]      s_sq;

   assign req.ready = (state_ff == F_IDLE);
   assign job       = cur_ff;
   assign job_valid = (state_ff == F_PUSH);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      dxx_in       = dxx_ff;
      dyy_in       = dyy_ff;
      d2_in        = d2_ff;
      s_in         = s_ff;
      m_in         = m_ff;
      dx = (cur_ff.pt_x > cur_ff.prev_x) ? cur_ff.pt_x - cur_ff.prev_x
                                         : cur_ff.prev_x - cur_ff.pt_x;
      dy = (cur_ff.pt_y > cur_ff.prev_y) ? cur_ff.pt_y - cur_ff.prev_y
                                         : cur_ff.prev_y - cur_ff.pt_y;
      s_sq = s_ff * s_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req.valid) begin
               cur_in.pt_x   = req.point_x;
               cur_in.pt_y   = req.point_y;
               cur_in.prev_x = prev_x_ff;
               cur_in.prev_y = prev_y_ff;
               cur_in.n_pts  = '0;
               cur_in.sat    = 1'b0;
               cur_in.fin    = req.final_point;
               prev_x_in     = req.point_x;
               prev_y_in     = req.point_y;
               have_prev_in  = !req.final_point;
               state_in      = have_prev_ff ? F_SQ : F_PUSH;
            end
         end
         F_SQ: begin
            dxx_in   = dx * dx;
            dyy_in   = dy * dy;
            state_in = F_SUM;
         end
         F_SUM: begin
            d2_in    = D2_W'(dxx_ff) + D2_W'(dyy_ff);
            s_in     = S_W'(max_gap);
            m_in     = CNT_W'(1);
            state_in = F_SRCH;
         end
         F_SRCH: begin
            // One multiple of the gap per cycle: the first one that reaches
            // the distance sets the number of inserted points.
            if (s_sq >= (2*S_W)'(d2_ff)) begin
               cur_in.n_pts = N_W'(m_ff - CNT_W'(1));
               state_in     = F_PUSH;
            end else if (m_ff == CNT_W'(MAX_INTERP + 1)) begin
               cur_in.n_pts = N_W'(MAX_INTERP);
               cur_in.sat   = 1'b1;
               state_in     = F_PUSH;
            end else begin
               m_in = m_ff + CNT_W'(1);
               s_in = s_ff + S_W'(max_gap);
            end
         end
         F_PUSH: begin
            if (job_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
      end
      cur_ff <= cur_in;
      dxx_ff <= dxx_in;
      dyy_ff <= dyy_in;
      d2_ff  <= d2_in;
      s_ff   <= s_in;
      m_ff   <= m_in;
   end

endmodule

// File: rtl/core/pgf_queue.sv
// Short job queue between the front end and the back end.
// Depends on pgf_pkg.
module pgf_queue import pgf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  job_type in_job,
   input  logic    in_valid,
   output logic    in_ready,
   output job_type out_job,
   output logic    out_valid,
   input  logic    out_ready
);

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              push, pop;

   assign in_ready  = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_job   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         cnt_ff <= cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

// File: rtl/core/pgf_back.sv
// Back end: interpolates the inserted points, keeps the point history, runs
// the smoothing filter and the end flush, and drives the result register.
// Depends on pgf_pkg and pgf_if.
module pgf_back import pgf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  job_type job,
   input  logic    job_valid,
   output logic    job_ready,
   pgf_rsp_if.source rsp
);

   localparam logic [3:0] B_IDLE  = 4'd0;
   localparam logic [3:0] B_NUM   = 4'd1;
   localparam logic [3:0] B_DIV   = 4'd2;
   localparam logic [3:0] B_SHIFT = 4'd3;
   localparam logic [3:0] B_SEL   = 4'd4;
   localparam logic [3:0] B_MAC   = 4'd5;
   localparam logic [3:0] B_ROUND = 4'd6;
   localparam logic [3:0] B_EMIT  = 4'd7;
   localparam logic [3:0] B_NEXT  = 4'd8;
   localparam logic [3:0] B_FLUSH = 4'd9;
   localparam logic [3:0] B_DONE  = 4'd10;

   logic [3:0]            state_ff, state_in;
   job_type               job_ff, job_in;
   logic [CNT_W-1:0]      j_ff, j_in;
   logic [NUM_W-1:0]      numx_ff, numx_in, numy_ff, numy_in;
   logic [CNT_W-1:0]      remx_ff, remx_in, remy_ff, remy_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [COORD_BITS-1:0] pnt_x_ff, pnt_x_in, pnt_y_ff, pnt_y_in;
   logic [COORD_BITS-1:0] hx_ff [HIST];
   logic [COORD_BITS-1:0] hx_in [HIST];
   logic [COORD_BITS-1:0] hy_ff [HIST];
   logic [COORD_BITS-1:0] hy_in [HIST];
   logic [COORD_BITS-1:0] wlx_ff [HIST];
   logic [COORD_BITS-1:0] wlx_in [HIST];
   logic [COORD_BITS-1:0] whx_ff [HIST];
   logic [COORD_BITS-1:0] whx_in [HIST];
   logic [COORD_BITS-1:0] wly_ff [HIST];
   logic [COORD_BITS-1:0] wly_in [HIST];
   logic [COORD_BITS-1:0] why_ff [HIST];
   logic [COORD_BITS-1:0] why_in [HIST];
   logic [HIST_W-1:0]     count_ff, count_in;
   logic [HALF_W-1:0]     d_ff, d_in, r_ff, r_in;
   logic [ACC_W-1:0]      accx_ff, accx_in, accy_ff, accy_in;
   logic [COORD_BITS-1:0] cand_x_ff, cand_x_in, cand_y_ff, cand_y_in;
   logic                  cand_sm_ff, cand_sm_in;
   logic [COORD_BITS-1:0] pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic                  pend_sm_ff, pend_sm_in, pend_v_ff, pend_v_in;
   logic                  flush_ff, flush_in;
   logic [COORD_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                  out_sm_ff, out_sm_in, out_sat_ff, out_sat_in;
   logic                  out_eor_ff, out_eor_in, out_v_ff, out_v_in;

   logic [HALF_W-1:0]     h;
   logic [CNT_W-1:0]      den, j_nxt, n_ext;
   logic [CNT_W:0]        tx, ty;
   logic [COORD_BITS:0]   termx, termy;
   logic [WGT_W-1:0]      wgt;
   logic [ACC_W-1:0]      rsx, rsy;
   logic                  out_free;
   int                    widx;

   assign h        = eff_half(cfg.half_window);
   assign den      = CNT_W'(job_ff.n_pts) + CNT_W'(1);
   assign n_ext    = CNT_W'(job_ff.n_pts);
   assign j_nxt    = j_ff + CNT_W'(1);
   assign out_free = !out_v_ff || rsp.ready;
   assign job_ready = (state_ff == B_IDLE);

   assign rsp.valid         = out_v_ff;
   assign rsp.out_x         = out_x_ff;
   assign rsp.out_y         = out_y_ff;
   assign rsp.was_smoothed  = out_sm_ff;
   assign rsp.gap_saturated = out_sat_ff;
   assign rsp.end_of_run    = out_eor_ff;

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      j_in       = j_ff;
      numx_in    = numx_ff;
      numy_in    = numy_ff;
      remx_in    = remx_ff;
      remy_in    = remy_ff;
      div_cnt_in = div_cnt_ff;
      pnt_x_in   = pnt_x_ff;
      pnt_y_in   = pnt_y_ff;
      hx_in      = hx_ff;
      hy_in      = hy_ff;
      wlx_in     = wlx_ff;
      whx_in     = whx_ff;
      wly_in     = wly_ff;
      why_in     = why_ff;
      count_in   = count_ff;
      d_in       = d_ff;
      r_in       = r_ff;
      accx_in    = accx_ff;
      accy_in    = accy_ff;
      cand_x_in  = cand_x_ff;
      cand_y_in  = cand_y_ff;
      cand_sm_in = cand_sm_ff;
      pend_x_in  = pend_x_ff;
      pend_y_in  = pend_y_ff;
      pend_sm_in = pend_sm_ff;
      pend_v_in  = pend_v_ff;
      flush_in   = flush_ff;
      out_x_in   = out_x_ff;
      out_y_in   = out_y_ff;
      out_sm_in  = out_sm_ff;
      out_sat_in = out_sat_ff;
      out_eor_in = out_eor_ff;
      out_v_in   = out_v_ff && !rsp.ready;
      tx    = {remx_ff, numx_ff[NUM_W-1]};
      ty    = {remy_ff, numy_ff[NUM_W-1]};
      termx = (d_ff == '0) ? {1'b0, wlx_ff[0]} : {1'b0, wlx_ff[0]} + {1'b0, whx_ff[0]};
      termy = (d_ff == '0) ? {1'b0, wly_ff[0]} : {1'b0, wly_ff[0]} + {1'b0, why_ff[0]};
      wgt   = tap_weight(cfg, d_ff);
      rsx   = accx_ff + ACC_W'(ROUND_ADD);
      rsy   = accy_ff + ACC_W'(ROUND_ADD);
      widx  = 0;

      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_in = job;
               j_in   = CNT_W'(1);
               if (job.n_pts != '0) begin
                  state_in = B_NUM;
               end else begin
                  pnt_x_in = job.pt_x;
                  pnt_y_in = job.pt_y;
                  state_in = B_SHIFT;
               end
            end
         end
         B_NUM: begin
            numx_in = NUM_W'(j_ff * job_ff.pt_x) + NUM_W'((den - j_ff) * job_ff.prev_x)
                    + NUM_W'(den >> 1);
            numy_in = NUM_W'(j_ff * job_ff.pt_y) + NUM_W'((den - j_ff) * job_ff.prev_y)
                    + NUM_W'(den >> 1);
            remx_in    = '0;
            remy_in    = '0;
            div_cnt_in = '0;
            state_in   = B_DIV;
         end
         B_DIV: begin
            // Restoring division, one quotient bit per cycle; the quotient
            // bits shift into the numerator register.
            if (div_cnt_ff == DIV_CNT_W'(NUM_W)) begin
               pnt_x_in = numx_ff[COORD_BITS-1:0];
               pnt_y_in = numy_ff[COORD_BITS-1:0];
               state_in = B_SHIFT;
            end else begin
               if (tx >= {1'b0, den}) begin
                  remx_in = CNT_W'(tx - {1'b0, den});
                  numx_in = {numx_ff[NUM_W-2:0], 1'b1};
               end else begin
                  remx_in = CNT_W'(tx);
                  numx_in = {numx_ff[NUM_W-2:0], 1'b0};
               end
               if (ty >= {1'b0, den}) begin
                  remy_in = CNT_W'(ty - {1'b0, den});
                  numy_in = {numy_ff[NUM_W-2:0], 1'b1};
               end else begin
                  remy_in = CNT_W'(ty);
                  numy_in = {numy_ff[NUM_W-2:0], 1'b0};
               end
               div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            end
         end
         B_SHIFT: begin
            for (int i = HIST - 1; i > 0; i--) begin
               hx_in[i] = hx_ff[i-1];
               hy_in[i] = hy_ff[i-1];
            end
            hx_in[0] = pnt_x_ff;
            hy_in[0] = pnt_y_ff;
            if (count_ff < HIST_W'(HIST)) begin
               count_in = count_ff + HIST_W'(1);
            end
            state_in = B_SEL;
         end
         B_SEL: begin
            if (count_ff <= HIST_W'(h)) begin
               state_in = B_NEXT;
            end else if (count_ff < HIST_W'({h, 1'b0}) + HIST_W'(1)) begin
               cand_x_in  = hx_ff[HIDX_W'(h)];
               cand_y_in  = hy_ff[HIDX_W'(h)];
               cand_sm_in = 1'b0;
               state_in   = B_EMIT;
            end else begin
               // The low window runs upward from the newest point, the high
               // window downward from the oldest point of the span.
               for (int i = 0; i < HIST; i++) begin
                  wlx_in[i] = hx_ff[i];
                  wly_in[i] = hy_ff[i];
                  widx = 2 * int'(h) - i;
                  if (widx >= 0) begin
                     whx_in[i] = hx_ff[HIDX_W'(widx)];
                     why_in[i] = hy_ff[HIDX_W'(widx)];
                  end
               end
               d_in     = h;
               accx_in  = '0;
               accy_in  = '0;
               state_in = B_MAC;
            end
         end
         B_MAC: begin
            accx_in = accx_ff + ACC_W'(wgt * termx);
            accy_in = accy_ff + ACC_W'(wgt * termy);
            for (int i = 0; i < HIST - 1; i++) begin
               wlx_in[i] = wlx_ff[i+1];
               whx_in[i] = whx_ff[i+1];
               wly_in[i] = wly_ff[i+1];
               why_in[i] = why_ff[i+1];
            end
            if (d_ff == '0) begin
               state_in = B_ROUND;
            end else begin
               d_in = d_ff - HALF_W'(1);
            end
         end
         B_ROUND: begin
            cand_x_in  = (|rsx[ACC_W-1:FRAC_W+COORD_BITS]) ? COORD_MASK
                                                           : rsx[FRAC_W+COORD_BITS-1:FRAC_W];
            cand_y_in  = (|rsy[ACC_W-1:FRAC_W+COORD_BITS]) ? COORD_MASK
                                                           : rsy[FRAC_W+COORD_BITS-1:FRAC_W];
            cand_sm_in = 1'b1;
            state_in   = B_EMIT;
         end
         B_EMIT: begin
            // A result is held back one step so the last one of a waypoint
            // can be tagged when the step ends.
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  out_x_in   = pend_x_ff;
                  out_y_in   = pend_y_ff;
                  out_sm_in  = pend_sm_ff;
                  out_sat_in = job_ff.sat;
                  out_eor_in = 1'b0;
                  out_v_in   = 1'b1;
               end
               pend_x_in  = cand_x_ff;
               pend_y_in  = cand_y_ff;
               pend_sm_in = cand_sm_ff;
               pend_v_in  = 1'b1;
               state_in   = flush_ff ? B_FLUSH : B_NEXT;
            end
         end
         B_NEXT: begin
            if (j_ff <= n_ext) begin
               j_in = j_nxt;
               if (j_nxt <= n_ext) begin
                  state_in = B_NUM;
               end else begin
                  pnt_x_in = job_ff.pt_x;
                  pnt_y_in = job_ff.pt_y;
                  state_in = B_SHIFT;
               end
            end else if (job_ff.fin) begin
               r_in     = (count_ff < HIST_W'(h)) ? HALF_W'(count_ff) : h;
               flush_in = 1'b1;
               state_in = B_FLUSH;
            end else begin
               state_in = B_DONE;
            end
         end
         B_FLUSH: begin
            if (r_ff == '0) begin
               state_in = B_DONE;
            end else begin
               cand_x_in  = hx_ff[HIDX_W'(r_ff - HALF_W'(1))];
               cand_y_in  = hy_ff[HIDX_W'(r_ff - HALF_W'(1))];
               cand_sm_in = 1'b0;
               r_in       = r_ff - HALF_W'(1);
               state_in   = B_EMIT;
            end
         end
         B_DONE: begin
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  out_x_in   = pend_x_ff;
                  out_y_in   = pend_y_ff;
                  out_sm_in  = pend_sm_ff;
                  out_sat_in = job_ff.sat;
                  out_eor_in = 1'b1;
                  out_v_in   = 1'b1;
               end
               pend_v_in = 1'b0;
               flush_in  = 1'b0;
               if (job_ff.fin) begin
                  count_in = '0;
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         count_ff <= '0;
         pend_v_ff <= 1'b0;
         flush_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_v_ff <= pend_v_in;
         flush_ff  <= flush_in;
         out_v_ff  <= out_v_in;
      end
      job_ff     <= job_in;
      j_ff       <= j_in;
      numx_ff    <= numx_in;
      numy_ff    <= numy_in;
      remx_ff    <= remx_in;
      remy_ff    <= remy_in;
      div_cnt_ff <= div_cnt_in;
      pnt_x_ff   <= pnt_x_in;
      pnt_y_ff   <= pnt_y_in;
      for (int i = 0; i < HIST; i++) begin
         hx_ff[i]  <= hx_in[i];
         hy_ff[i]  <= hy_in[i];
         wlx_ff[i] <= wlx_in[i];
         whx_ff[i] <= whx_in[i];
         wly_ff[i] <= wly_in[i];
         why_ff[i] <= why_in[i];
      end
      d_ff       <= d_in;
      r_ff       <= r_in;
      accx_ff    <= accx_in;
      accy_ff    <= accy_in;
      cand_x_ff  <= cand_x_in;
      cand_y_ff  <= cand_y_in;
      cand_sm_ff <= cand_sm_in;
      pend_x_ff  <= pend_x_in;
      pend_y_ff  <= pend_y_in;
      pend_sm_ff <= pend_sm_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_sm_ff  <= out_sm_in;
      out_sat_ff <= out_sat_in;
      out_eor_ff <= out_eor_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= HIST_W'(HIST))
      else $error("filled point count above history depth");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_IDLE |-> !pend_v_ff)
      else $error("held result left over at start of a waypoint");

   a_mac_offset: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_MAC |-> d_ff <= h)
      else $error("filter offset beyond half window");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_DIV |-> div_cnt_ff <= DIV_CNT_W'(NUM_W))
      else $error("divider ran past its bit count");

endmodule

// File: rtl/core/path_gap_fill_gaussian_smoother_core.sv
// Top level of the path gap filler and Gaussian smoother: configuration
// registers, front end, job queue and back end.
// Depends on pgf_pkg, pgf_if, pgf_front, pgf_queue and pgf_back.
//
//   Channel    Direction  Word contents
//   req_chan   in         point_x, point_y, final_point
//   rsp_chan   out        out_x, out_y, was_smoothed, gap_saturated, end_of_run
//   csr_*      in         csr_we, csr_index, csr_wdata (write only)
//
// The front end takes one waypoint at a time. One that opens a path needs only
// the accept and hand-over steps; any other one is accepted, gets its squared
// distance in two steps, tests one multiple of max_gap per step and is handed over.
// In the back end each inserted point is first interpolated: one step forms the
// numerators, then the serial divider runs. Every point is then shifted in,
// selected and stepped on, plus an emit step when it leaves unchanged, or one MAC
// step per offset up to half_window, a rounding and an emit step when filtered.
// A flushed end point takes flush and emit steps; a job adds accept and done steps.
// A two-word job queue lets the front end measure the next gap while the back end
// is still busy.
// Reset is synchronous and clears the path state; there is no clearing pass.
// A stalled result port holds the back end once its held result cannot move.
module path_gap_fill_gaussian_smoother_core import pgf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   pgf_req_if.sink              req_chan,
   pgf_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   job_type front_job, queue_job;
   logic    front_valid, front_ready, queue_valid, queue_ready;

   // Configuration writes land here; an index past the list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MAX_GAP:     cfg_in.max_gap     = csr_wdata[GAP_W-1:0];
            REG_HALF_WINDOW: cfg_in.half_window = csr_wdata[HWIN_W-1:0];
            REG_W_CENTER:    cfg_in.weight[0]   = csr_wdata[WGT_W-1:0];
            REG_W_OFF1:      cfg_in.weight[1]   = csr_wdata[WGT_W-1:0];
            REG_W_OFF2:      cfg_in.weight[2]   = csr_wdata[WGT_W-1:0];
            REG_W_OFF3:      cfg_in.weight[3]   = csr_wdata[WGT_W-1:0];
            REG_W_OFF4:      cfg_in.weight[4]   = csr_wdata[WGT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_gap     <= RST_MAX_GAP;
         cfg_ff.half_window <= RST_HALF_WINDOW;
         cfg_ff.weight[0]   <= RST_W_CENTER;
         cfg_ff.weight[1]   <= RST_W_OFF1;
         cfg_ff.weight[2]   <= RST_W_OFF2;
         cfg_ff.weight[3]   <= RST_W_OFF3;
         cfg_ff.weight[4]   <= RST_W_OFF4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end measures each gap and hands one job per waypoint onward.
   pgf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .max_gap   (cfg_ff.max_gap),
      .job       (front_job),
      .job_valid (front_valid),
      .job_ready (front_ready)
   );

   pgf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_job    (front_job),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_job   (queue_job),
      .out_valid (queue_valid),
      .out_ready (queue_ready)
   );

   // The back end fills, filters and flushes, and owns the result register.
   pgf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job       (queue_job),
      .job_valid (queue_valid),
      .job_ready (queue_ready),
      .rsp       (rsp_chan)
   );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for path_gap_fill_gaussian_smoother_core: directed and
// random waypoint paths, a local gap-fill and smoothing predictor, and checks of every word.
// Depends on pgf_pkg, pgf_if and the core RTL.
module tb_top;
   import pgf_pkg::*;

   localparam int IDLE_LIMIT   = 5000;  // cycles without any handshake before giving up
   localparam int SETTLE_WAIT  = 800;   // worst back end time for words that produce nothing
   localparam int RANDOM_PHASES = 8;
   localparam int POINTS_PER_PHASE = 17;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  smoothed;
      logic                  saturated;
      logic                  last;
   } path_point_type;

   typedef enum logic { ROW_WRITE, ROW_POINT } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_W-1:0]      value;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  fin;
      logic                  typed;   // expected single pass-through word given below
      logic [COORD_BITS-1:0] typed_x;
      logic [COORD_BITS-1:0] typed_y;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   pgf_req_if req_chan();
   pgf_rsp_if rsp_chan();

   path_gap_fill_gaussian_smoother_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Mirror of the block's configuration and path state. The predictor below
   // keeps these in step with every accepted waypoint.
   cfg_type               shadow_cfg;
   logic [COORD_BITS-1:0] hist_x [HIST];
   logic [COORD_BITS-1:0] hist_y [HIST];
   logic [COORD_BITS-1:0] last_x, last_y;
   logic                  path_open;
   int                    filled_total;

   path_point_type pending_points[$];   // words the block still owes, oldest first
   path_point_type step_points[$];      // words caused by the waypoint being predicted
   stim_row_type   directed_rows[$];

   int  mismatch_count = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;                // no idling on either side in the last part

   // The effective half width is clipped to the number of offset taps that exist.
   function automatic int active_half();
      return (shadow_cfg.half_window > MAX_HALF) ? MAX_HALF : int'(shadow_cfg.half_window);
   endfunction

   // Symmetric FIR over the history, centered on entry h, rounded and saturated.
   function automatic logic [COORD_BITS-1:0] fir_at(input logic [COORD_BITS-1:0] v [HIST],
                                                    input int h);
      logic [63:0] acc;
      acc = 64'(v[h]) * 64'(shadow_cfg.weight[0]);
      for (int d = 1; d <= h; d++) begin
         acc += (64'(v[h-d]) + 64'(v[h+d])) * 64'(shadow_cfg.weight[d]);
      end
      acc = (acc + 64'(ROUND_ADD)) >> FRAC_W;
      return (acc > 64'(COORD_MASK)) ? COORD_MASK : acc[COORD_BITS-1:0];
   endfunction

   // Shift one densified point into the history. Once more than h points are
   // in, the point h back leaves either unchanged (near the path start) or filtered.
   task automatic push_filled(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                              input logic sat);
      int             h;
      path_point_type p;
      h = active_half();
      for (int i = HIST - 1; i > 0; i--) begin
         hist_x[i] = hist_x[i-1];
         hist_y[i] = hist_y[i-1];
      end
      hist_x[0] = x;
      hist_y[0] = y;
      if (filled_total < HIST) filled_total++;
      if (filled_total <= h) return;
      p.saturated = sat;
      p.last = 1'b0;
      if (filled_total < 2 * h + 1) begin
         p.x = hist_x[h];
         p.y = hist_y[h];
         p.smoothed = 1'b0;
      end else begin
         p.x = fir_at(hist_x, h);
         p.y = fir_at(hist_y, h);
         p.smoothed = 1'b1;
      end
      step_points.insert(step_points.size(), p);
   endtask

   // Works out every word one accepted waypoint causes and leaves them in step_points.
   task automatic smooth_waypoint(input logic [COORD_BITS-1:0] x,
                                  input logic [COORD_BITS-1:0] y, input logic fin);
      logic [63:0]    dx, dy, d2, g, s, den, ix, iy;
      int             n, h, r;
      logic           sat;
      path_point_type p;
      step_points.delete();
      n = 0;
      sat = 1'b0;
      if (path_open) begin
         dx = (x > last_x) ? 64'(x - last_x) : 64'(last_x - x);
         dy = (y > last_y) ? 64'(y - last_y) : 64'(last_y - y);
         d2 = dx * dx + dy * dy;
         g = 64'(shadow_cfg.max_gap);
         if (d2 > g * g) begin
            n = MAX_INTERP;
            sat = 1'b1;
            for (int m = 1; m <= MAX_INTERP + 1; m++) begin
               s = 64'(m) * g;
               if (s * s >= d2) begin
                  n = m - 1;
                  sat = 1'b0;
                  break;
               end
            end
         end
         den = 64'(n + 1);
         for (int j = 1; j <= n; j++) begin
            ix = (64'(j) * 64'(x) + (den - 64'(j)) * 64'(last_x) + den / 2) / den;
            iy = (64'(j) * 64'(y) + (den - 64'(j)) * 64'(last_y) + den / 2) / den;
            push_filled(ix[COORD_BITS-1:0], iy[COORD_BITS-1:0], sat);
         end
      end
      push_filled(x, y, sat);
      last_x = x;
      last_y = y;
      path_open = 1'b1;
      if (fin) begin
         // The tail of the path leaves unfiltered, oldest first.
         h = active_half();
         r = (filled_total < h) ? filled_total : h;
         while (r > 0) begin
            r--;
            p.x = hist_x[r];
            p.y = hist_y[r];
            p.smoothed = 1'b0;
            p.saturated = sat;
            p.last = 1'b0;
            step_points.insert(step_points.size(), p);
         end
         path_open = 1'b0;
         filled_total = 0;
      end
      if (step_points.size() > 0) step_points[step_points.size()-1].last = 1'b1;
   endtask

   // Waits until every owed word has arrived and the back end has surely finished.
   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (pending_points.size() > 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         REG_MAX_GAP:     shadow_cfg.max_gap = val[GAP_W-1:0];
         REG_HALF_WINDOW: shadow_cfg.half_window = val[HWIN_W-1:0];
         REG_W_CENTER:    shadow_cfg.weight[0] = val[WGT_W-1:0];
         REG_W_OFF1:      shadow_cfg.weight[1] = val[WGT_W-1:0];
         REG_W_OFF2:      shadow_cfg.weight[2] = val[WGT_W-1:0];
         REG_W_OFF3:      shadow_cfg.weight[3] = val[WGT_W-1:0];
         REG_W_OFF4:      shadow_cfg.weight[4] = val[WGT_W-1:0];
         default: ;
      endcase
   endtask

   // Offers one waypoint word, possibly after a random gap, and records what it owes
   // once accepted. Called and returning at a falling edge.
   task automatic send_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                             input logic fin, input logic typed,
                             input logic [COORD_BITS-1:0] tx,
                             input logic [COORD_BITS-1:0] ty);
      path_point_type p;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.point_x = x;
      req_chan.point_y = y;
      req_chan.final_point = fin;
      do @(posedge clock); while (!req_chan.ready);
      smooth_waypoint(x, y, fin);
      if (typed) begin
         // A lone waypoint of its own path comes straight back as one word.
         p.x = tx;
         p.y = ty;
         p.smoothed = 1'b0;
         p.saturated = 1'b0;
         p.last = 1'b1;
         pending_points.insert(pending_points.size(), p);
      end else begin
         foreach (step_points[i]) pending_points.insert(pending_points.size(), step_points[i]);
      end
      @(negedge clock);
   endtask

   task automatic add_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      stim_row_type row;
      row = '{ROW_WRITE, idx, val, '0, '0, 1'b0, 1'b0, '0, '0};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic add_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic fin);
      stim_row_type row;
      row = '{ROW_POINT, '0, '0, x, y, fin, 1'b0, '0, '0};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic add_typed(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
      stim_row_type row;
      row = '{ROW_POINT, '0, '0, x, y, 1'b1, 1'b1, x, y};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   function automatic logic [COORD_BITS-1:0] rand_coord();
      return COORD_BITS'($urandom);
   endfunction

   // Next waypoint of a random path: mostly a step of a few gap lengths from the
   // last one, sometimes a jump anywhere on the grid.
   function automatic logic [COORD_BITS-1:0] step_coord(input logic [COORD_BITS-1:0] from);
      longint reach, v;
      if ($urandom_range(0, 9) < 2) return rand_coord();
      reach = longint'(shadow_cfg.max_gap) * $urandom_range(0, 5);
      v = longint'(from) + longint'($urandom_range(0, 1000)) * reach / 1000
          - ((($urandom_range(0, 1)) == 1) ? 2 * longint'($urandom_range(0, 1000)) * reach / 1000
                                           : 0);
      if (v < 0) v = 0;
      if (v > longint'(COORD_MASK)) v = longint'(COORD_MASK);
      return COORD_BITS'(v);
   endfunction

   // The result side stalls in random bursts, except in the last part of the run.
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         @(negedge clock);
      end
   end

   // Compares each delivered word with the oldest one owed, field by field.
   always @(posedge clock) begin
      path_point_type want;
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected word x=%h y=%h", rsp_chan.out_x, rsp_chan.out_y);
         end else begin
            want = pending_points.pop_front();
            if (rsp_chan.out_x !== want.x || rsp_chan.out_y !== want.y ||
                rsp_chan.was_smoothed !== want.smoothed ||
                rsp_chan.gap_saturated !== want.saturated ||
                rsp_chan.end_of_run !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"ERROR: expected x=%h y=%h sm=%b sat=%b end=%b, ",
                            "got x=%h y=%h sm=%b sat=%b end=%b"},
                           want.x, want.y, want.smoothed, want.saturated, want.last,
                           rsp_chan.out_x, rsp_chan.out_y, rsp_chan.was_smoothed,
                           rsp_chan.gap_saturated, rsp_chan.end_of_run);
            end
         end
      end
   end

   // Watchdog: too long without any handshake on either channel ends the run.
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("path_gap_fill_gaussian_smoother_core verification failed");
      $finish;
   end

   initial begin
      int plen;
      logic [COORD_BITS-1:0] px, py;
      req_chan.valid = 1'b0;
      req_chan.point_x = '0;
      req_chan.point_y = '0;
      req_chan.final_point = 1'b0;
      shadow_cfg.max_gap = RST_MAX_GAP;
      shadow_cfg.half_window = RST_HALF_WINDOW;
      shadow_cfg.weight[0] = RST_W_CENTER;
      shadow_cfg.weight[1] = RST_W_OFF1;
      shadow_cfg.weight[2] = RST_W_OFF2;
      shadow_cfg.weight[3] = RST_W_OFF3;
      shadow_cfg.weight[4] = RST_W_OFF4;
      path_open = 1'b0;
      filled_total = 0;
      last_x = '0;
      last_y = '0;
      foreach (hist_x[i]) begin
         hist_x[i] = '0;
         hist_y[i] = '0;
      end

      // Directed part. Reset settings first: lone waypoints at both grid corners.
      add_typed('0, '0);
      add_typed(COORD_MASK, COORD_MASK);
      // A gap of two spacings gets one inserted point; repeated points add none;
      // a corner to corner jump needs more inserts than allowed and saturates.
      add_point(20'd100, 20'd100, 1'b0);
      add_point(20'd600, 20'd100, 1'b0);
      add_point(20'd600, 20'd700, 1'b0);
      add_point(20'd5, 20'd5, 1'b0);
      add_point(20'd5, 20'd5, 1'b0);
      add_point('0, '0, 1'b0);
      add_point(COORD_MASK, COORD_MASK, 1'b1);
      // Half width above the tap count acts as the largest one; full weights
      // drive the filtered output into saturation.
      add_write(REG_HALF_WINDOW, 20'd7);
      add_write(REG_W_CENTER, 20'hFFFF);
      add_write(REG_W_OFF1, 20'hFFFF);
      add_write(REG_W_OFF3, 20'd4096);
      add_write(REG_W_OFF4, 20'd2048);
      add_point(COORD_MASK, '0, 1'b0);
      add_point(COORD_MASK, 20'd1000, 1'b0);
      add_point(20'hFF000, 20'd2000, 1'b0);
      add_point(20'hAAAAA, 20'h55555, 1'b0);
      add_point(20'h55555, 20'hAAAAA, 1'b1);
      // Zero gap limit: every nonzero move saturates, standing still inserts nothing.
      // Zero half width filters every point with the center weight alone.
      add_write(REG_MAX_GAP, 20'd0);
      add_write(REG_HALF_WINDOW, 20'd0);
      add_point(20'd10, 20'd10, 1'b0);
      add_point(20'd10, 20'd10, 1'b0);
      add_point(20'd20, 20'd30, 1'b1);
      // Largest gap limit, then a half width change in the middle of a path.
      add_write(REG_MAX_GAP, 20'hFFFFF);
      add_write(REG_HALF_WINDOW, 20'd4);
      add_point(20'd1, 20'd2, 1'b0);
      add_point(20'd3, 20'd4, 1'b0);
      add_write(REG_HALF_WINDOW, 20'd1);
      add_point(20'd5, 20'd6, 1'b1);
      // All weights zero: filtered points come out as zero.
      add_write(REG_W_CENTER, 20'd0);
      add_write(REG_W_OFF1, 20'd0);
      add_write(REG_W_OFF2, 20'd0);
      add_write(REG_W_OFF3, 20'd0);
      add_write(REG_W_OFF4, 20'd0);
      add_write(REG_HALF_WINDOW, 20'd3);
      add_point(20'h80000, 20'h7FFFF, 1'b0);
      add_point('0, '0, 1'b0);
      add_point(COORD_MASK, COORD_MASK, 1'b0);
      add_point(20'd7, 20'd9, 1'b0);
      add_point(20'd8, 20'd9, 1'b0);
      add_point(20'd9, 20'd9, 1'b1);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_idle();
            write_reg(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].fin,
                       directed_rows[i].typed, directed_rows[i].typed_x,
                       directed_rows[i].typed_y);
         end
      end

      // Random part: each phase picks a fresh setting, then runs whole paths.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         quiet = (ph == RANDOM_PHASES - 1);
         case ($urandom_range(0, 5))
            0:       write_reg(REG_MAX_GAP, 20'd1);
            1:       write_reg(REG_MAX_GAP, CSR_W'($urandom_range(0, 1048575)));
            default: write_reg(REG_MAX_GAP, CSR_W'($urandom_range(16, 8192)));
         endcase
         write_reg(REG_HALF_WINDOW, CSR_W'($urandom_range(0, 7)));
         if ($urandom_range(0, 2) == 0) begin
            write_reg(REG_W_CENTER, CSR_W'($urandom_range(0, 65535)));
            write_reg(REG_W_OFF1, CSR_W'($urandom_range(0, 65535)));
            write_reg(REG_W_OFF2, CSR_W'($urandom_range(0, 65535)));
            write_reg(REG_W_OFF3, CSR_W'($urandom_range(0, 65535)));
            write_reg(REG_W_OFF4, CSR_W'($urandom_range(0, 65535)));
         end else begin
            // A roughly normalized bell shape keeps outputs on the grid.
            write_reg(REG_W_CENTER, CSR_W'($urandom_range(16000, 30000)));
            write_reg(REG_W_OFF1, CSR_W'($urandom_range(10000, 16000)));
            write_reg(REG_W_OFF2, CSR_W'($urandom_range(3000, 8000)));
            write_reg(REG_W_OFF3, CSR_W'($urandom_range(500, 3000)));
            write_reg(REG_W_OFF4, CSR_W'($urandom_range(0, 1000)));
         end
         plen = 0;
         px = rand_coord();
         py = rand_coord();
         for (int k = 0; k < POINTS_PER_PHASE; k++) begin
            if (plen == 0) plen = $urandom_range(1, 12);
            plen--;
            send_point(px, py, (plen == 0) || (k == POINTS_PER_PHASE - 1),
                       1'b0, '0, '0);
            if (k == POINTS_PER_PHASE - 1) plen = 0;
            px = step_coord(px);
            py = step_coord(py);
         end
      end

      req_chan.valid = 1'b0;
      while (pending_points.size() > 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
      if (mismatch_count == 0 && pending_points.size() == 0) begin
         $display("path_gap_fill_gaussian_smoother_core verification clean");
      end else begin
         $display("path_gap_fill_gaussian_smoother_core verification failed");
      end
      $finish;
   end

endmodule

// File: path_gap_fill_gaussian_smoother_core.f
rtl/core/pgf_pkg.sv
rtl/core/pgf_if.sv
rtl/core/pgf_front.sv
rtl/core/pgf_queue.sv
rtl/core/pgf_back.sv
rtl/core/path_gap_fill_gaussian_smoother_core.sv
tb/sv/tb_top.sv
